// ===== rtl/hsvtm_pkg.sv =====
// Shared types and constants of the HSV threshold mask unit.
`default_nettype none

package hsvtm_pkg;

	localparam int unsigned ChanW   = 8;
	localparam int unsigned HueW    = 9;
	localparam int unsigned HueAltW = 10;
	localparam int unsigned SatW    = 9;
	localparam int unsigned NumW    = 17;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 10;

	localparam int HueScale     = 60;
	localparam int HueGreenBase = 120;
	localparam int HueBlueBase  = 240;
	localparam int HueFull      = 360;

	localparam logic [ChanW-1:0] MaskPass = 8'hFF;
	localparam logic [ChanW-1:0] MaskFail = 8'h00;

	typedef enum logic [CfgIdxW-1:0] {
		RegGreyLow    = 3'd0,
		RegGreyHigh   = 3'd1,
		RegHueLow     = 3'd2,
		RegHueHigh    = 3'd3,
		RegHueLowAlt  = 3'd4,
		RegHueHighAlt = 3'd5,
		RegValueFloor = 3'd6,
		RegSatFloor   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [ChanW-1:0]          grey_low;
		logic [ChanW-1:0]          grey_high;
		logic [HueW-1:0]           hue_low;
		logic [HueW-1:0]           hue_high;
		logic signed [HueAltW-1:0] hue_low_alt;
		logic signed [HueAltW-1:0] hue_high_alt;
		logic [ChanW-1:0]          value_floor;
		logic [SatW-1:0]           saturation_floor;
	} cfg_t;

	// Hue as the fraction num / den, with den forced to one for a grey pixel.
	typedef struct packed {
		logic [ChanW-1:0] max_chan;
		logic [ChanW-1:0] delta;
		logic [ChanW-1:0] den;
		logic [NumW-1:0]  num;
		logic             flat;
	} hsv_t;

endpackage

`default_nettype wire

// ===== rtl/hsvtm_cfg_regs.sv =====
// Configuration register file of the HSV threshold mask unit.
`default_nettype none

module hsvtm_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [hsvtm_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [hsvtm_pkg::CfgDatW-1:0] cfg_data,
	output hsvtm_pkg::cfg_t                    cfg
);

	hsvtm_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grey_low         <= '0;
			cfg_q.grey_high        <= '1;
			cfg_q.hue_low          <= '0;
			cfg_q.hue_high         <= hsvtm_pkg::HueW'(hsvtm_pkg::HueFull);
			cfg_q.hue_low_alt      <= '1;
			cfg_q.hue_high_alt     <= '1;
			cfg_q.value_floor      <= '0;
			cfg_q.saturation_floor <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (hsvtm_pkg::reg_idx_t'(cfg_index))
				hsvtm_pkg::RegGreyLow:    cfg_q.grey_low     <= cfg_data[7:0];
				hsvtm_pkg::RegGreyHigh:   cfg_q.grey_high    <= cfg_data[7:0];
				hsvtm_pkg::RegHueLow:     cfg_q.hue_low      <= cfg_data[8:0];
				hsvtm_pkg::RegHueHigh:    cfg_q.hue_high     <= cfg_data[8:0];
				hsvtm_pkg::RegHueLowAlt:  cfg_q.hue_low_alt  <= cfg_data;
				hsvtm_pkg::RegHueHighAlt: cfg_q.hue_high_alt <= cfg_data;
				hsvtm_pkg::RegValueFloor: cfg_q.value_floor  <= cfg_data[7:0];
				hsvtm_pkg::RegSatFloor:   cfg_q.saturation_floor <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hsvtm_hsv.sv =====
// RGB to HSV conversion: max, delta and hue as an exact fraction.
`default_nettype none

module hsvtm_hsv (
	input  wire logic [hsvtm_pkg::ChanW-1:0] red,
	input  wire logic [hsvtm_pkg::ChanW-1:0] green,
	input  wire logic [hsvtm_pkg::ChanW-1:0] blue,
	output hsvtm_pkg::hsv_t                  hsv
);

	logic [hsvtm_pkg::ChanW-1:0] mx;
	logic [hsvtm_pkg::ChanW-1:0] mn;
	logic [hsvtm_pkg::ChanW-1:0] delta;
	logic signed [19:0]          diff_rg;
	logic signed [19:0]          diff_gb;
	logic signed [19:0]          diff_br;
	logic signed [19:0]          dlt_s;
	logic signed [19:0]          num_s;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx)  mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn)  mn = blue;
	end

	assign delta   = mx - mn;
	assign dlt_s   = 20'(signed'({1'b0, delta}));
	assign diff_rg = 20'(signed'({1'b0, red}))   - 20'(signed'({1'b0, green}));
	assign diff_gb = 20'(signed'({1'b0, green})) - 20'(signed'({1'b0, blue}));
	assign diff_br = 20'(signed'({1'b0, blue}))  - 20'(signed'({1'b0, red}));

	// Ties go to red first, then green.
	always_comb begin
		if (mx == red) begin
			num_s = diff_gb * 20'sd60;
			if (num_s < 0) num_s = num_s + dlt_s * 20'sd360;
		end else if (mx == green) begin
			num_s = diff_br * 20'sd60 + dlt_s * 20'sd120;
		end else begin
			num_s = diff_rg * 20'sd60 + dlt_s * 20'sd240;
		end
	end

	always_comb begin
		hsv.max_chan = mx;
		hsv.delta    = delta;
		hsv.flat     = (delta == '0);
		hsv.den      = hsv.flat ? hsvtm_pkg::ChanW'(1) : delta;
		hsv.num      = hsv.flat ? '0 : num_s[hsvtm_pkg::NumW-1:0];
	end

endmodule

`default_nettype wire

// ===== rtl/hsvtm_check.sv =====
// Threshold checks on grey, hue, value and saturation of one pixel.
`default_nettype none

module hsvtm_check (
	input  wire logic [hsvtm_pkg::ChanW-1:0] grey_level,
	input  hsvtm_pkg::hsv_t                  hsv,
	input  hsvtm_pkg::cfg_t                  cfg,
	output logic                             pass
);

	localparam int unsigned NW = hsvtm_pkg::NumW;

	logic [NW-1:0] lo_prod;
	logic [NW-1:0] hi_prod;
	logic [NW-1:0] lo_alt_prod;
	logic [NW-1:0] hi_alt_prod;
	logic [NW-1:0] sat_lhs;
	logic [NW-1:0] sat_rhs;
	logic          grey_ok;
	logic          hue_main_ok;
	logic          hue_alt_ok;
	logic          val_ok;
	logic          sat_ok;

	assign lo_prod     = NW'(cfg.hue_low) * NW'(hsv.den);
	assign hi_prod     = NW'(cfg.hue_high) * NW'(hsv.den);
	assign lo_alt_prod = NW'(cfg.hue_low_alt[8:0]) * NW'(hsv.den);
	assign hi_alt_prod = NW'(cfg.hue_high_alt[8:0]) * NW'(hsv.den);

	assign grey_ok     = (grey_level >= cfg.grey_low) && (grey_level <= cfg.grey_high);
	assign hue_main_ok = (hsv.num >= lo_prod) && (hsv.num <= hi_prod);
	// A negative low bound switches the second window off; a negative high
	// bound lies below every hue and so matches nothing.
	assign hue_alt_ok  = !cfg.hue_low_alt[9] && !cfg.hue_high_alt[9]
		&& (hsv.num >= lo_alt_prod) && (hsv.num <= hi_alt_prod);
	assign val_ok      = (hsv.max_chan >= cfg.value_floor);

	assign sat_lhs = {1'b0, hsv.delta, 8'h00};
	assign sat_rhs = NW'(cfg.saturation_floor) * NW'(hsv.max_chan);
	assign sat_ok  = hsv.flat ? (cfg.saturation_floor == '0) : (sat_lhs >= sat_rhs);

	assign pass = grey_ok && (hue_main_ok || hue_alt_ok) && val_ok && sat_ok;

endmodule

`default_nettype wire

// ===== rtl/hsv_threshold_mask_unit.sv =====
// Top level of the HSV threshold mask unit: handshakes, pipeline registers, checks.
// Usage:
//   Pixels enter on the input channel (in_valid / in_stall) as a grey byte and
//   red, green and blue bytes. For each pixel the unit returns one mask byte on
//   the output channel (out_valid / out_stall): 255 when the pixel passes the
//   grey, hue, value and saturation checks, otherwise 0.
//   A transaction takes place on a rising edge where valid is high and stall low.
//   Thresholds are written over the configuration channel (cfg_valid, cfg_ready,
//   cfg_index, cfg_data) while no pixel is in flight; cfg_ready is always high.
//   Throughput is one pixel per cycle while the receiver does not stall.
//   out_valid rises when the pixel moves from the input register into the result
//   register. The path holds one input register, one layer of conversion and
//   compare logic, one result register. The compare layer, with its small
//   multipliers of hue bounds by delta, sets the clock period.
//   When the receiver stalls, the result register holds its mask byte and the
//   input register still takes one further pixel; only when both are full does
//   in_stall rise.
//   Reset empties both pipeline registers and loads the default thresholds:
//   full grey range, hue window 0 to 360, second window off, no value or
//   saturation floor.
`default_nettype none

module hsv_threshold_mask_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [hsvtm_pkg::ChanW-1:0]   grey_level,
	input  wire logic [hsvtm_pkg::ChanW-1:0]   red,
	input  wire logic [hsvtm_pkg::ChanW-1:0]   green,
	input  wire logic [hsvtm_pkg::ChanW-1:0]   blue,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [hsvtm_pkg::ChanW-1:0]        mask_byte,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [hsvtm_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [hsvtm_pkg::CfgDatW-1:0] cfg_data
);

	hsvtm_pkg::cfg_t             cfg;
	hsvtm_pkg::hsv_t             hsv;
	logic                        valid_s1;
	logic [hsvtm_pkg::ChanW-1:0] grey_s1;
	logic [hsvtm_pkg::ChanW-1:0] red_s1;
	logic [hsvtm_pkg::ChanW-1:0] green_s1;
	logic [hsvtm_pkg::ChanW-1:0] blue_s1;
	logic                        valid_s2;
	logic [hsvtm_pkg::ChanW-1:0] mask_s2;
	logic                        pass;
	logic                        in_take;
	logic                        out_take;
	logic                        adv_s2;

	hsvtm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hsvtm_hsv u_hsv (
		.red   (red_s1),
		.green (green_s1),
		.blue  (blue_s1),
		.hsv   (hsv)
	);

	hsvtm_check u_check (
		.grey_level (grey_s1),
		.hsv        (hsv),
		.cfg        (cfg),
		.pass       (pass)
	);

	// The result register moves on when it is empty or its mask byte is being
	// taken this cycle; the input register then frees up as well.
	assign out_take = valid_s2 && !out_stall;
	assign adv_s2   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s2;
	assign in_take  = in_valid && !in_stall;

	assign out_valid = valid_s2;
	assign mask_byte = mask_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (out_take) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			grey_s1  <= grey_level;
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
		end
		if (adv_s2) begin
			mask_s2 <= pass ? hsvtm_pkg::MaskPass : hsvtm_pkg::MaskFail;
		end
	end

	// Stall is only raised while the input register holds a pixel.
	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> valid_s1)
		else $error("in_stall raised with an empty input register");

	// A pixel moving into the result register is presented next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) adv_s2 |=> out_valid)
		else $error("advanced pixel not presented on the output");

	// The mask byte is only ever all ones or all zeros.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mask_byte == hsvtm_pkg::MaskPass || mask_byte == hsvtm_pkg::MaskFail))
		else $error("mask byte neither pass nor fail");

endmodule

`default_nettype wire
